[rtl/rmf_pkg.sv]
// Package for the running max filter: pixel width, reset window, result type.
package rmf_pkg;

   localparam int PIXEL_W      = 8;
   localparam int CFG_W        = 6;
   localparam int WINDOW_RESET = 31;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type max_value;
      logic      last_in_row;
   } result_type;

endpackage

[rtl/rmf_cell.sv]
// One cell of the max chain: holds the max of the last (k+1) pixels.
module rmf_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  rmf_pkg::pixel_type pixel_in,
   input  rmf_pkg::pixel_type prev_max,
   output rmf_pkg::pixel_type max_in,
   output rmf_pkg::pixel_type max_q
);

   rmf_pkg::pixel_type max_ff;

   // new max over k+1 pixels = max(new pixel, old max over k pixels)
   assign max_in = (pixel_in > prev_max) ? pixel_in : prev_max;
   assign max_q  = max_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         max_ff <= max_in;
      end
   end

endmodule

[rtl/rmf_out_buf.sv]
// Output register with one skid entry for the result channel.
module rmf_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               res_valid,
   input  rmf_pkg::result_type res_data,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output rmf_pkg::result_type out_data
);

   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   rmf_pkg::result_type out_data_ff, out_data_in;
   rmf_pkg::result_type skid_data_ff, skid_data_in;
   logic               out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign room      = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // no new item can arrive while the skid is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res_data;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

[rtl/running_max_filter_1d_core.sv]
// Top level of the running max filter: cell chain, fill count, config, output buffer.
//
// Sliding maximum along a row of 8-bit pixels (horizontal grey-scale dilation).
// req_ channel: one pixel item with row_start / row_end flags. row_start clears
// the window fill before the pixel is taken in.
// rsp_ channel: one result item per pixel once the row holds at least
// window_size pixels: the max of the last window_size pixels plus the row_end
// flag of the pixel that made it. Items with too little fill give no result.
// csr_ channel: writes window_size (0 acts as 1, above MAX_WINDOW acts as
// MAX_WINDOW); csr_ready is always high. Write it only while the block is idle.
// Results are registered in the output buffer. Throughput: one item per cycle
// while req_ready is high. Each cell of the chain keeps the max of the
// last k+1 pixels and updates with one compare against the new pixel, so no
// path is longer than one compare plus the width select.
// Stall: the output register plus one skid entry let an item be accepted while
// a result waits; req_ready drops only when the skid entry is taken.
// Reset: synchronous, clears fill count, result valids, and sets window_size
// to 31. No clearing pass; the block is ready the cycle after reset.
module running_max_filter_1d_core #(
   parameter int MAX_WINDOW = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rmf_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                              req_row_start,
   input  logic                              req_row_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rmf_pkg::PIXEL_W-1:0]       rsp_max_value,
   output logic                              rsp_last_in_row,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rmf_pkg::CFG_W-1:0]         csr_window_size
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int CMP_W = (CNT_W > rmf_pkg::CFG_W) ? CNT_W : rmf_pkg::CFG_W;
   localparam int RESET_W = (rmf_pkg::WINDOW_RESET > MAX_WINDOW) ?
                            MAX_WINDOW : rmf_pkg::WINDOW_RESET;
   localparam logic [IDX_W-1:0] RESET_IDX = IDX_W'(RESET_W - 1);
   localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_WINDOW);
   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_WINDOW);

   // effective width minus one, resolved when the register is written
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CMP_W-1:0] ws_ext;

   logic [CNT_W-1:0] fill_ff, fill_in, fill_base;
   logic             accept;
   logic             res_valid;
   rmf_pkg::result_type res_data, out_data;
   logic             room;

   rmf_pkg::pixel_type max_next [MAX_WINDOW];
   rmf_pkg::pixel_type max_held [MAX_WINDOW];

   assign csr_ready = 1'b1;
   assign ws_ext    = CMP_W'(csr_window_size);

   always_comb begin
      if (ws_ext == '0) begin
         idx_in = '0;
      end else if (ws_ext > MAX_CMP) begin
         idx_in = IDX_W'(MAX_WINDOW - 1);
      end else begin
         idx_in = IDX_W'(ws_ext - CMP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= RESET_IDX;
      end else if (csr_valid) begin
         idx_ff <= idx_in;
      end
   end

   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   // fill saturates at MAX_WINDOW; row start restarts it
   assign fill_base = req_row_start ? '0 : fill_ff;
   assign fill_in   = (fill_base == MAX_CNT) ? fill_base : fill_base + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   // chain of max cells; cell k holds the max of the last k+1 pixels
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      rmf_pkg::pixel_type prev;
      if (k == 0) begin : g_head
         assign prev = '0;
      end else begin : g_link
         assign prev = max_held[k-1];
      end
      rmf_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .pixel_in (req_pixel),
         .prev_max (prev),
         .max_in   (max_next[k]),
         .max_q    (max_held[k])
      );
   end

   // result once fill reaches the effective width (fill > width - 1)
   assign res_valid            = accept && (fill_in > CNT_W'(idx_ff));
   assign res_data.max_value   = max_next[idx_ff];
   assign res_data.last_in_row = req_row_end;

   rmf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_max_value   = out_data.max_value;
   assign rsp_last_in_row = out_data.last_in_row;

   // input only stalls while a result is pending in the buffer
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_CNT)
      else $error("fill count above max window");

   a_width_one: assert property (@(posedge clock) disable iff (reset)
      (accept && idx_ff == '0) |-> res_valid)
      else $error("width one item gave no result");

   a_row_start_wide: assert property (@(posedge clock) disable iff (reset)
      (accept && req_row_start && idx_ff != '0) |-> !res_valid)
      else $error("row start gave a result with width above one");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
